### rtl/keyframe_frame_ring_multireader_macros.svh
`ifndef KEYFRAME_FRAME_RING_MULTIREADER_MACROS_SVH
`define KEYFRAME_FRAME_RING_MULTIREADER_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define KFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define KFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/kfr_pkg.sv
package kfr_pkg;

  localparam int POS_W  = 24;
  localparam int BSZ_W  = 25;
  localparam int BASE_W = 16;
  localparam int CNT_W  = 32;
  localparam int TS_W   = 64;
  localparam int REST_W = TS_W + CNT_W + 1 + POS_W;

  localparam logic [0:0] CFG_BUFFER_SIZE = 1'b0;
  localparam logic [0:0] CFG_DATA_BASE   = 1'b1;

  localparam logic [24:0] BSZ_RESET  = 25'd1048576;
  localparam logic [15:0] BASE_RESET = 16'd2048;

  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_EMPTY     = 3'd1;
  localparam logic [2:0] STS_REJECT    = 3'd2;
  localparam logic [2:0] STS_SKIPPED   = 3'd3;
  localparam logic [2:0] STS_TOO_SMALL = 3'd4;
  localparam logic [2:0] STS_NO_READER = 3'd5;

  typedef enum logic [2:0] {
    MODE_PUT     = 3'd0,
    MODE_GET     = 3'd1,
    MODE_ATTACH  = 3'd2,
    MODE_RELEASE = 3'd3,
    MODE_RESYNC  = 3'd4,
    MODE_CLEAR   = 3'd5,
    MODE_SAVED   = 3'd6,
    MODE_WRESET  = 3'd7
  } mode_e;

  typedef enum logic [4:0] {
    A_NONE, A_LOAD, A_CLR, A_PWP, A_NEXTR, A_REJ, A_NKSTART, A_NKEXH,
    A_NKCATCH, A_NKFOUND, A_NKSTEP, A_BWRAP, A_COMMIT, A_GET, A_GEMPTY,
    A_BADR, A_ATTACH, A_RELEASE, A_RESYNC, A_CLRALL, A_WRESET, A_SWP, A_SAVED
  } act_e;

  typedef enum logic [1:0] {
    RS_HEAD, RS_TAIL, RS_WALK
  } rsel_e;

  typedef enum logic [1:0] {
    W_NEXT, W_CATCH, W_FOUND
  } wres_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISP, S_P_WP, S_P_RSEL, S_P_RCHK, S_P_WALK, S_P_WCHK,
    S_P_BWRAP, S_P_SIZE, S_G_DATA, S_S_WP, S_S_RP, S_OUT
  } st_e;

  typedef struct packed {
    act_e  act;
    rsel_e rsel;
    logic  rd;
  } dp_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  reader_oob;
    logic  len_zero;
    logic  blocking;
    logic  cur_end;
    logic  cur_used;
    logic  tail_head;
    logic  nhead_tail;
    logic  blk_fail;
    logic  push_hit;
    logic  walk_last;
    logic  walk_head;
    wres_e wres;
    logic  too_big;
    logic  clr_last;
  } dp_sts_t;

endpackage

### rtl/keyframe_frame_ring_multireader.sv
// Attach, release, resync, clear, writer reset, an empty get and a zero-length put go from
// dispatch straight to the result; get and saved bytes first read the descriptor memories.
// Put visits every reader slot and checks each attached reader, and a blocking put adds a wrap step;
// an overwriting put walks the ring to the next keyframe for each pushed reader.
// One item at a time: the next item is accepted only after the result has been taken.
// After reset the descriptor memories are cleared while input is stalled.
module keyframe_frame_ring_multireader #(
  parameter int RING_SLOTS  = 64,
  parameter int MAX_READERS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [24:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  mode_i,
  input  logic [1:0]  reader_i,
  input  logic [23:0] length_i,
  input  logic        key_frame_i,
  input  logic        blocking_i,
  input  logic [63:0] timestamp_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [23:0] address_o,
  output logic [23:0] frame_length_o,
  output logic        is_key_o,
  output logic [63:0] frame_time_o,
  output logic [31:0] unread_count_o,
  output logic [1:0]  reader_index_o,
  output logic [24:0] saved_bytes_o
);
  import kfr_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  kfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  kfr_dp #(
    .RING_SLOTS  (RING_SLOTS),
    .MAX_READERS (MAX_READERS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .mode_i         (mode_i),
    .reader_i       (reader_i),
    .length_i       (length_i),
    .key_frame_i    (key_frame_i),
    .blocking_i     (blocking_i),
    .timestamp_ms_i (timestamp_ms_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .status_o       (status_o),
    .address_o      (address_o),
    .frame_length_o (frame_length_o),
    .is_key_o       (is_key_o),
    .frame_time_o   (frame_time_o),
    .unread_count_o (unread_count_o),
    .reader_index_o (reader_index_o),
    .saved_bytes_o  (saved_bytes_o)
  );

endmodule

### rtl/kfr_ram.sv
module kfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/kfr_ctrl.sv
module kfr_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            out_stall_i,
  input  kfr_pkg::dp_sts_t sts_i,
  output kfr_pkg::dp_cmd_t cmd_o,
  output logic            in_stall_o,
  output logic            out_valid_o
);
  import kfr_pkg::*;

  st_e st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLEAR;
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    st_d        = st_q;
    cmd_o       = '{act: A_NONE, rsel: RS_HEAD, rd: 1'b0};
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (st_q)
      S_CLEAR: begin
        cmd_o.act = A_CLR;
        if (sts_i.clr_last) begin
          st_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.act = A_LOAD;
          st_d      = S_DISP;
        end
      end
      S_DISP: begin
        st_d = S_OUT;
        if (sts_i.reader_oob && (sts_i.mode inside {MODE_GET, MODE_RELEASE, MODE_RESYNC,
                                                    MODE_SAVED})) begin
          cmd_o.act = A_BADR;
        end else begin
          unique case (sts_i.mode)
            MODE_PUT: begin
              if (sts_i.len_zero) begin
                cmd_o.act = A_REJ;
              end else begin
                cmd_o.rd = 1'b1;
                st_d     = S_P_WP;
              end
            end
            MODE_GET: begin
              if (sts_i.tail_head) begin
                cmd_o.act = A_GEMPTY;
              end else begin
                cmd_o.rd   = 1'b1;
                cmd_o.rsel = RS_TAIL;
                st_d       = S_G_DATA;
              end
            end
            MODE_ATTACH:  cmd_o.act = A_ATTACH;
            MODE_RELEASE: cmd_o.act = A_RELEASE;
            MODE_RESYNC:  cmd_o.act = A_RESYNC;
            MODE_CLEAR:   cmd_o.act = A_CLRALL;
            MODE_SAVED: begin
              cmd_o.rd = 1'b1;
              st_d     = S_S_WP;
            end
            MODE_WRESET:  cmd_o.act = A_WRESET;
            default:      cmd_o.act = A_NONE;
          endcase
        end
      end
      S_P_WP: begin
        cmd_o.act = A_PWP;
        st_d      = S_P_RSEL;
      end
      S_P_RSEL: begin
        if (sts_i.cur_end) begin
          st_d = sts_i.blocking ? S_P_BWRAP : S_P_SIZE;
        end else if (!sts_i.cur_used) begin
          cmd_o.act = A_NEXTR;
        end else if (sts_i.blocking && sts_i.tail_head) begin
          cmd_o.act = A_NEXTR;
        end else if (sts_i.blocking && sts_i.nhead_tail) begin
          cmd_o.act = A_REJ;
          st_d      = S_OUT;
        end else begin
          cmd_o.rd   = 1'b1;
          cmd_o.rsel = RS_TAIL;
          st_d       = S_P_RCHK;
        end
      end
      S_P_RCHK: begin
        if (sts_i.blocking) begin
          if (sts_i.blk_fail) begin
            cmd_o.act = A_REJ;
            st_d      = S_OUT;
          end else begin
            cmd_o.act = A_NEXTR;
            st_d      = S_P_RSEL;
          end
        end else if (sts_i.push_hit) begin
          cmd_o.act = A_NKSTART;
          st_d      = S_P_WALK;
        end else begin
          cmd_o.act = A_NEXTR;
          st_d      = S_P_RSEL;
        end
      end
      S_P_WALK: begin
        if (sts_i.walk_last) begin
          cmd_o.act = A_NKEXH;
          st_d      = S_P_RSEL;
        end else if (sts_i.walk_head) begin
          cmd_o.act = A_NKCATCH;
          st_d      = S_P_RSEL;
        end else begin
          cmd_o.rd   = 1'b1;
          cmd_o.rsel = RS_WALK;
          st_d       = S_P_WCHK;
        end
      end
      S_P_WCHK: begin
        unique case (sts_i.wres)
          W_CATCH: begin
            cmd_o.act = A_NKCATCH;
            st_d      = S_P_RSEL;
          end
          W_FOUND: begin
            cmd_o.act = A_NKFOUND;
            st_d      = S_P_RSEL;
          end
          default: begin
            cmd_o.act = A_NKSTEP;
            st_d      = S_P_WALK;
          end
        endcase
      end
      S_P_BWRAP: begin
        cmd_o.act = A_BWRAP;
        st_d      = S_P_SIZE;
      end
      S_P_SIZE: begin
        cmd_o.act = sts_i.too_big ? A_REJ : A_COMMIT;
        st_d      = S_OUT;
      end
      S_G_DATA: begin
        cmd_o.act = A_GET;
        st_d      = S_OUT;
      end
      S_S_WP: begin
        cmd_o.act  = A_SWP;
        cmd_o.rd   = 1'b1;
        cmd_o.rsel = RS_TAIL;
        st_d       = S_S_RP;
      end
      S_S_RP: begin
        cmd_o.act = A_SAVED;
        st_d      = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

endmodule

### rtl/kfr_dp.sv
module kfr_dp #(
  parameter int RING_SLOTS  = 64,
  parameter int MAX_READERS = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [24:0]      cfg_wdata_i,
  input  logic [2:0]       mode_i,
  input  logic [1:0]       reader_i,
  input  logic [23:0]      length_i,
  input  logic             key_frame_i,
  input  logic             blocking_i,
  input  logic [63:0]      timestamp_ms_i,
  input  kfr_pkg::dp_cmd_t cmd_i,
  output kfr_pkg::dp_sts_t sts_o,
  output logic [2:0]       status_o,
  output logic [23:0]      address_o,
  output logic [23:0]      frame_length_o,
  output logic             is_key_o,
  output logic [63:0]      frame_time_o,
  output logic [31:0]      unread_count_o,
  output logic [1:0]       reader_index_o,
  output logic [24:0]      saved_bytes_o
);
  import kfr_pkg::*;

  localparam int SW = $clog2(RING_SLOTS);
  localparam int RW = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
  localparam int CW = $clog2(MAX_READERS + 1);
  localparam logic [SW-1:0] LAST = SW'(RING_SLOTS - 1);

  function automatic logic [SW-1:0] nxt(input logic [SW-1:0] s);
    return (s == LAST) ? '0 : s + 1'b1;
  endfunction

  logic [24:0] bs_q;
  logic [15:0] db_q;

  logic [2:0]  mode_q;
  logic [1:0]  reader_q;
  logic [23:0] len_q;
  logic        key_q;
  logic        blk_q;
  logic [63:0] ts_q;

  logic [SW-1:0] wslot_q;
  logic [31:0]   wc_q, wn_q;
  logic          r_used_q [MAX_READERS];
  logic [SW-1:0] r_slot_q [MAX_READERS];
  logic [31:0]   r_cnt_q  [MAX_READERS];
  logic [31:0]   r_num_q  [MAX_READERS];
  logic          r_sync_q [MAX_READERS];

  logic [CW-1:0] cur_q;
  logic [SW-1:0] walk_q, step_q, clr_q;
  logic          jump_q;
  logic [23:0]   wp_q, old_q;

  logic [2:0]  res_status_q;
  logic [23:0] res_addr_q, res_flen_q;
  logic        res_key_q;
  logic [63:0] res_time_q;
  logic [31:0] res_unread_q;
  logic [1:0]  res_ridx_q;
  logic [24:0] res_saved_q;

  logic              pos_we, rest_we, rd_en;
  logic [SW-1:0]     pos_waddr, rest_waddr, raddr;
  logic [23:0]       pos_wdata, pos_rd;
  logic [REST_W-1:0] rest_wdata, rest_rd;

  logic [RW-1:0] cidx;
  logic [SW-1:0] head, nhead, tail;
  logic [23:0]   rp, slen;
  logic          skey, take;
  logic [31:0]   snum, lagd, rdiff;
  logic          lag;
  logic [24:0]   wpl, rawsum, dbl, wmr, bwmr, saved;
  logic          wrap_rd, wrap_wq, jump, over;
  logic          free_found;
  logic [RW-1:0] fidx;
  logic [1:0]    fidx2;
  wres_e         wres;

  assign cidx  = cur_q[RW-1:0];
  assign head  = wslot_q;
  assign nhead = nxt(wslot_q);
  assign tail  = r_slot_q[cidx];
  assign rp    = pos_rd;
  assign slen  = rest_rd[23:0];
  assign skey  = rest_rd[24];
  assign snum  = rest_rd[56:25];
  assign take  = (len_q >= slen);

  assign lagd  = wn_q - r_num_q[cidx];
  assign lag   = (lagd >= 32'd2) && !lagd[31];
  assign wpl   = {1'b0, wp_q} + {1'b0, len_q};
  assign rawsum = {1'b0, pos_rd} + {1'b0, len_q};
  assign dbl   = {9'd0, db_q} + {1'b0, len_q};
  assign wrap_rd = (rawsum >= bs_q) || (pos_rd < {8'd0, db_q});
  assign wrap_wq = (wpl >= bs_q) || (wp_q < {8'd0, db_q});
  assign over  = (wp_q < rp) && (wpl >= {1'b0, rp});
  assign jump  = (tail != head) && (old_q != '0) && (old_q <= rp);

  assign wmr   = {1'b0, wp_q} - {1'b0, rp};
  assign bwmr  = bs_q + {1'b0, wp_q} - {1'b0, rp};
  assign rdiff = wn_q - r_num_q[cidx];

  always_comb begin
    saved = '0;
    if (rdiff != '0 && !rdiff[31]) begin
      if (head >= tail) begin
        saved = (wp_q > rp) ? wmr : bwmr;
      end else if (wp_q <= rp) begin
        saved = bwmr;
      end
    end
  end

  always_comb begin
    wres = W_NEXT;
    if (skey) begin
      if (!(jump_q && (old_q < rp))) begin
        if (wp_q == rp) begin
          wres = W_CATCH;
        end else if (!over) begin
          wres = W_FOUND;
        end
      end
    end else if (wp_q == rp) begin
      wres = W_CATCH;
    end
  end

  always_comb begin
    free_found = 1'b0;
    fidx       = '0;
    fidx2      = '0;
    for (int i = 0; i < MAX_READERS; i++) begin
      if (!r_used_q[i] && !free_found) begin
        free_found = 1'b1;
        fidx       = RW'(i);
        fidx2      = 2'(i);
      end
    end
  end

  always_comb begin
    sts_o.mode       = mode_e'(mode_q);
    sts_o.reader_oob = (32'(reader_q) >= 32'(MAX_READERS));
    sts_o.len_zero   = (len_q == '0);
    sts_o.blocking   = blk_q;
    sts_o.cur_end    = (cur_q == CW'(MAX_READERS));
    sts_o.cur_used   = r_used_q[cidx];
    sts_o.tail_head  = (tail == head);
    sts_o.nhead_tail = (nhead == tail);
    sts_o.blk_fail   = ((wp_q <= rp) && (wpl >= {1'b0, rp})) ||
                       ((wpl >= bs_q) && (dbl > {1'b0, rp}));
    sts_o.push_hit   = (tail == head) ? (lag && (old_q != '0)) :
                       (jump || over || ((wp_q == rp) && lag));
    sts_o.walk_last  = (step_q == LAST);
    sts_o.walk_head  = (walk_q == head);
    sts_o.wres       = wres;
    sts_o.too_big    = ({1'b0, len_q} >= (bs_q >> 1));
    sts_o.clr_last   = (clr_q == LAST);
  end

  always_comb begin
    pos_we     = 1'b0;
    pos_waddr  = head;
    pos_wdata  = {8'd0, db_q};
    rest_we    = 1'b0;
    rest_waddr = head;
    rest_wdata = {ts_q, wn_q + 32'd1, key_q, len_q};
    case (cmd_i.act)
      A_CLR: begin
        pos_we     = 1'b1;
        pos_waddr  = clr_q;
        pos_wdata  = '0;
        rest_we    = 1'b1;
        rest_waddr = clr_q;
        rest_wdata = '0;
      end
      A_PWP:   pos_we = !blk_q && wrap_rd;
      A_BWRAP: pos_we = wrap_wq;
      A_COMMIT: begin
        pos_we    = 1'b1;
        pos_waddr = nhead;
        pos_wdata = wpl[23:0];
        rest_we   = 1'b1;
      end
      default: pos_we = 1'b0;
    endcase
    rd_en = cmd_i.rd;
    case (cmd_i.rsel)
      RS_TAIL: raddr = tail;
      RS_WALK: raddr = walk_q;
      default: raddr = head;
    endcase
  end

  kfr_ram #(.WIDTH(POS_W), .DEPTH(RING_SLOTS)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pos_waddr),
    .wdata_i (pos_wdata),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (pos_rd)
  );

  kfr_ram #(.WIDTH(REST_W), .DEPTH(RING_SLOTS)) u_rest_ram (
    .clk_i   (clk_i),
    .we_i    (rest_we),
    .waddr_i (rest_waddr),
    .wdata_i (rest_wdata),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (rest_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q <= BSZ_RESET;
      db_q <= BASE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BUFFER_SIZE: bs_q <= cfg_wdata_i;
        CFG_DATA_BASE:   db_q <= cfg_wdata_i[15:0];
        default:         bs_q <= bs_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      wslot_q <= '0;
      wc_q    <= '0;
      wn_q    <= '0;
      for (int i = 0; i < MAX_READERS; i++) begin
        r_used_q[i] <= 1'b0;
        r_slot_q[i] <= '0;
        r_cnt_q[i]  <= '0;
        r_num_q[i]  <= '0;
        r_sync_q[i] <= 1'b0;
      end
    end else begin
      case (cmd_i.act)
        A_CLR: clr_q <= clr_q + 1'b1;
        A_ATTACH: begin
          if (free_found) begin
            r_used_q[fidx] <= 1'b1;
            r_slot_q[fidx] <= wslot_q;
            r_sync_q[fidx] <= 1'b0;
            r_cnt_q[fidx]  <= wc_q;
            r_num_q[fidx]  <= wn_q;
          end
        end
        A_RELEASE: begin
          r_used_q[cidx] <= 1'b0;
          r_slot_q[cidx] <= '0;
          r_cnt_q[cidx]  <= '0;
        end
        A_RESYNC: begin
          r_slot_q[cidx] <= wslot_q;
          r_sync_q[cidx] <= 1'b0;
          r_cnt_q[cidx]  <= wc_q;
          r_num_q[cidx]  <= wn_q;
        end
        A_CLRALL: begin
          for (int i = 0; i < MAX_READERS; i++) begin
            if (r_used_q[i]) begin
              r_slot_q[i] <= wslot_q;
              r_sync_q[i] <= 1'b0;
              r_cnt_q[i]  <= wc_q;
              r_num_q[i]  <= wn_q;
            end
          end
        end
        A_WRESET: begin
          wslot_q <= '0;
          wc_q    <= '0;
          for (int i = 0; i < MAX_READERS; i++) begin
            if (!r_used_q[i]) begin
              r_slot_q[i] <= '0;
              r_cnt_q[i]  <= '0;
              r_sync_q[i] <= 1'b0;
            end
          end
        end
        A_GET: begin
          if (take) begin
            r_sync_q[cidx] <= r_sync_q[cidx] | skey;
            r_num_q[cidx]  <= snum;
            r_slot_q[cidx] <= nxt(tail);
            r_cnt_q[cidx]  <= r_cnt_q[cidx] + 32'd1;
          end
        end
        A_NKSTART: r_sync_q[cidx] <= 1'b0;
        A_NKCATCH: begin
          r_cnt_q[cidx]  <= r_cnt_q[cidx] + 32'(step_q);
          r_num_q[cidx]  <= wn_q;
          r_slot_q[cidx] <= head;
        end
        A_NKFOUND: begin
          r_sync_q[cidx] <= 1'b1;
          r_cnt_q[cidx]  <= r_cnt_q[cidx] + 32'(step_q);
          r_num_q[cidx]  <= snum;
          r_slot_q[cidx] <= walk_q;
        end
        A_NKEXH: begin
          r_cnt_q[cidx]  <= r_cnt_q[cidx] + 32'(RING_SLOTS);
          r_slot_q[cidx] <= head;
        end
        A_COMMIT: begin
          wslot_q <= nhead;
          wc_q    <= wc_q + 32'd1;
          wn_q    <= wn_q + 32'd1;
        end
        default: wc_q <= wc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.act)
      A_LOAD: begin
        mode_q       <= mode_i;
        reader_q     <= reader_i;
        len_q        <= length_i;
        key_q        <= key_frame_i;
        blk_q        <= blocking_i;
        ts_q         <= timestamp_ms_i;
        cur_q        <= CW'(reader_i);
        res_status_q <= STS_OK;
        res_addr_q   <= '0;
        res_flen_q   <= '0;
        res_key_q    <= 1'b0;
        res_time_q   <= '0;
        res_unread_q <= '0;
        res_ridx_q   <= '0;
        res_saved_q  <= '0;
      end
      A_PWP: begin
        cur_q <= '0;
        if (blk_q || !wrap_rd) begin
          wp_q  <= pos_rd;
          old_q <= '0;
        end else begin
          wp_q  <= {8'd0, db_q};
          old_q <= pos_rd;
        end
      end
      A_BWRAP: begin
        if (wrap_wq) begin
          wp_q <= {8'd0, db_q};
        end
      end
      A_SWP: wp_q <= pos_rd;
      A_NEXTR, A_NKCATCH, A_NKFOUND, A_NKEXH: cur_q <= cur_q + 1'b1;
      A_NKSTART: begin
        walk_q <= nxt(tail);
        step_q <= '0;
        jump_q <= jump;
      end
      A_NKSTEP: begin
        walk_q <= nxt(walk_q);
        step_q <= step_q + 1'b1;
      end
      A_REJ:  res_status_q <= STS_REJECT;
      A_BADR: res_status_q <= STS_NO_READER;
      A_COMMIT: begin
        res_addr_q <= wp_q;
        res_flen_q <= len_q;
        res_key_q  <= key_q;
        res_time_q <= ts_q;
      end
      A_GEMPTY: begin
        res_status_q <= STS_EMPTY;
        res_unread_q <= wn_q - r_num_q[cidx];
      end
      A_GET: begin
        res_key_q  <= skey;
        res_time_q <= rest_rd[REST_W-1:REST_W-TS_W];
        res_flen_q <= slen;
        if (take) begin
          res_addr_q   <= rp;
          res_status_q <= (skey || r_sync_q[cidx]) ? STS_OK : STS_SKIPPED;
          res_unread_q <= wn_q - snum;
        end else begin
          res_status_q <= STS_TOO_SMALL;
          res_unread_q <= wn_q - r_num_q[cidx];
        end
      end
      A_ATTACH: begin
        res_status_q <= free_found ? STS_OK : STS_NO_READER;
        res_ridx_q   <= free_found ? fidx2 : 2'd0;
      end
      A_SAVED: res_saved_q <= saved;
      default: res_saved_q <= res_saved_q;
    endcase
  end

  assign status_o       = res_status_q;
  assign address_o      = res_addr_q;
  assign frame_length_o = res_flen_q;
  assign is_key_o       = res_key_q;
  assign frame_time_o   = res_time_q;
  assign unread_count_o = res_unread_q;
  assign reader_index_o = res_ridx_q;
  assign saved_bytes_o  = res_saved_q;

endmodule

### rtl/kfr_checker.sv
`include "keyframe_frame_ring_multireader_macros.svh"

module kfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] status_o
);

  `KFR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped")
  `KFR_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(status_o), "result moved")
  `KFR_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "second item")
  `KFR_ASSERT_NOW(a_no_accept_pending, out_valid_o, in_stall_o, "accept with result pending")
  `KFR_ASSERT_NOW(a_status_code, out_valid_o, status_o != 3'd6 && status_o != 3'd7, "bad status")

endmodule

bind keyframe_frame_ring_multireader kfr_checker u_kfr_checker (.*);
